FILE: design/ratcont_pkg.sv
// ----------------------------------------------------------------------------
// ratcont_pkg
// Shared constants and types for the continued fraction expansion block.
// ----------------------------------------------------------------------------
package ratcont_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int FIELD_BITS         = 32;
  localparam int TERM_BITS          = 32;
  localparam int MAX_TERMS          = 48;
  localparam int COUNT_BITS         = $clog2(MAX_TERMS);

  // Operation of the shared subtract unit.
  typedef enum logic {
    ALU_SHIFT_SUB = 1'b0,  // restoring division step: (rem:next bit) - divisor
    ALU_SUB       = 1'b1   // plain subtract: divisor - remainder
  } alu_op_e;

endpackage

FILE: design/ratcont_alu.sv
// ----------------------------------------------------------------------------
// ratcont_alu
// Shared subtract unit. It performs either one restoring division step or
// the remainder correction of a floor division with a negative dividend.
// ----------------------------------------------------------------------------
module ratcont_alu
  import ratcont_pkg::*;
#(
  parameter int MAG_BITS = 32
) (
  input  alu_op_e               op_i,
  input  logic [MAG_BITS-1:0]   rem_i,
  input  logic                  next_bit_i,
  input  logic [MAG_BITS-1:0]   den_i,
  output logic [MAG_BITS-1:0]   result_o,
  output logic                  quot_bit_o
);

  localparam int SW = MAG_BITS + 2;

  logic [SW-1:0] sub_a;
  logic [SW-1:0] sub_b;
  logic [SW-1:0] diff;
  logic          borrow;

  always_comb begin
    case (op_i)
      ALU_SHIFT_SUB: begin
        sub_a = {1'b0, rem_i, next_bit_i};
        sub_b = {2'b00, den_i};
      end
      ALU_SUB: begin
        sub_a = {2'b00, den_i};
        sub_b = {2'b00, rem_i};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
    diff   = sub_a - sub_b;
    borrow = diff[SW-1];
    // A restoring step keeps the shifted remainder when the trial subtract
    // borrows; it then always fits, since it is below the divisor.
    if (op_i == ALU_SHIFT_SUB && borrow) begin
      result_o = sub_a[MAG_BITS-1:0];
    end else begin
      result_o = diff[MAG_BITS-1:0];
    end
    quot_bit_o = ~borrow;
  end

endmodule

FILE: design/rational_continued_fraction.sv
// ----------------------------------------------------------------------------
// rational_continued_fraction
// Expands a signed fraction into its simple continued fraction terms.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one fraction per transfer (numerator and
//   denominator). The master channel gives one transfer per term; tlast marks
//   the final term of a fraction and tuser flags a zero denominator, for which
//   a single term of zero is sent.
//   The sign is moved to the numerator, so only the first term can be
//   negative. Each term is a floor quotient; the expansion stops at 48 terms.
//   Every term is computed by a restoring divider that reuses one subtract
//   unit: one quotient bit per cycle over MAG_BITS (VALUE_BITS, at most 32)
//   bits, then a correction step (ST_FIX) for a negative first term, then the
//   hand-over of the term to the output register (ST_EMIT).
//   s_axis_tready is high only while no fraction is in progress. The output
//   register lets a term wait while the next one is computed; when the
//   receiver stalls with a term still waiting, the sequencer holds.
//   Reset clears the sequencer and the output valid; no term is pending.
// ----------------------------------------------------------------------------
module rational_continued_fraction
  import ratcont_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [2*FIELD_BITS-1:0] s_axis_tdata,   // [31:0] numerator, [63:32] denominator
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [TERM_BITS-1:0]    m_axis_tdata,   // [31:0] term
  output logic                    m_axis_tlast,
  output logic                    m_axis_tuser    // [0] infinite
);

  localparam int MAG_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int CW       = $clog2(MAG_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [MAG_BITS-1:0]   num_q;     // dividend, shifted into the quotient
  logic [MAG_BITS-1:0]   den_q;
  logic [MAG_BITS-1:0]   rem_q;
  logic [CW-1:0]         bit_cnt_q;
  logic [COUNT_BITS-1:0] term_cnt_q;
  logic                  neg_q;
  logic                  inc_q;
  logic                  inf_q;
  logic                  m_valid_q;
  logic [TERM_BITS-1:0]  m_term_q;
  logic                  m_last_q;
  logic                  m_inf_q;

  // Input magnitudes and sign.
  logic [MAG_BITS-1:0] num_raw;
  logic [MAG_BITS-1:0] den_raw;
  logic [MAG_BITS-1:0] num_mag;
  logic [MAG_BITS-1:0] den_mag;
  logic                in_neg;

  assign num_raw = s_axis_tdata[MAG_BITS-1:0];
  assign den_raw = s_axis_tdata[FIELD_BITS+MAG_BITS-1:FIELD_BITS];
  assign num_mag = num_raw[MAG_BITS-1] ? (~num_raw + 1'b1) : num_raw;
  assign den_mag = den_raw[MAG_BITS-1] ? (~den_raw + 1'b1) : den_raw;
  assign in_neg  = num_raw[MAG_BITS-1] ^ den_raw[MAG_BITS-1];

  // Shared subtract unit.
  alu_op_e             alu_op;
  logic [MAG_BITS-1:0] alu_result;
  logic                alu_qbit;

  assign alu_op = (state_q == ST_FIX) ? ALU_SUB : ALU_SHIFT_SUB;

  ratcont_alu #(
    .MAG_BITS (MAG_BITS)
  ) u_alu (
    .op_i       (alu_op),
    .rem_i      (rem_q),
    .next_bit_i (num_q[MAG_BITS-1]),
    .den_i      (den_q),
    .result_o   (alu_result),
    .quot_bit_o (alu_qbit)
  );

  // Term from the unsigned quotient: floor of a negative value is the negated
  // quotient, one further down when a remainder was left. Positive terms
  // saturate at the largest signed value.
  logic [TERM_BITS:0]   q_ext;
  logic [TERM_BITS:0]   q_sum;
  logic [TERM_BITS-1:0] term;
  logic                 done;
  logic                 out_free;
  logic                 emit_fire;

  always_comb begin
    q_ext = (TERM_BITS+1)'(num_q);
    q_sum = q_ext + (TERM_BITS+1)'(inc_q);
    if (neg_q) begin
      term = -q_sum[TERM_BITS-1:0];
    end else if (q_ext[TERM_BITS:TERM_BITS-1] != 2'b00) begin
      term = {1'b0, {(TERM_BITS-1){1'b1}}};
    end else begin
      term = q_ext[TERM_BITS-1:0];
    end
  end

  assign done      = (rem_q == '0) || (term_cnt_q == COUNT_BITS'(MAX_TERMS - 1));
  assign out_free  = ~m_valid_q | m_axis_tready;
  assign emit_fire = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_valid_q  <= 1'b0;
      m_term_q   <= '0;
      m_last_q   <= 1'b0;
      m_inf_q    <= 1'b0;
      num_q      <= '0;
      den_q      <= '0;
      rem_q      <= '0;
      bit_cnt_q  <= '0;
      term_cnt_q <= '0;
      neg_q      <= 1'b0;
      inc_q      <= 1'b0;
      inf_q      <= 1'b0;
    end else begin
      if (emit_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            term_cnt_q <= '0;
            inc_q      <= 1'b0;
            rem_q      <= '0;
            den_q      <= den_mag;
            bit_cnt_q  <= CW'(MAG_BITS - 1);
            if (den_mag == '0) begin
              // Infinite value: one zero term, flagged.
              num_q   <= '0;
              neg_q   <= 1'b0;
              inf_q   <= 1'b1;
              state_q <= ST_EMIT;
            end else begin
              num_q   <= num_mag;
              neg_q   <= in_neg;
              inf_q   <= 1'b0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q     <= alu_result;
          num_q     <= {num_q[MAG_BITS-2:0], alu_qbit};
          bit_cnt_q <= bit_cnt_q - 1'b1;
          if (bit_cnt_q == '0) begin
            state_q <= neg_q ? ST_FIX : ST_EMIT;
          end
        end
        ST_FIX: begin
          if (rem_q != '0) begin
            rem_q <= alu_result;
            inc_q <= 1'b1;
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_term_q  <= term;
            m_last_q  <= done;
            m_inf_q   <= inf_q;
            if (done) begin
              state_q <= ST_IDLE;
            end else begin
              num_q      <= den_q;
              den_q      <= rem_q;
              rem_q      <= '0;
              neg_q      <= 1'b0;
              inc_q      <= 1'b0;
              bit_cnt_q  <= CW'(MAG_BITS - 1);
              term_cnt_q <= term_cnt_q + 1'b1;
              state_q    <= ST_DIV;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_term_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_inf_q;

endmodule
